### src/http_chunked_body_decoder_defines.svh
// Assertion helpers for the decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Same-cycle implication, checked on clk and held off during reset.
`define HCBD_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on clk and held off during reset.
`define HCBD_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/hcbd_pkg.sv
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam int COUNT_BITS = 32;
    localparam int SIZE_BITS  = COUNT_BITS + 1;
    localparam int TOTAL_BITS = 32;
    localparam int SUM_BITS   = ((COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS) + 1;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_X_LO  = 8'h78;
    localparam logic [7:0] CHAR_X_UP  = 8'h58;

    localparam logic [TOTAL_BITS-1:0] MAX_BODY_RESET = 32'd16777216;

    typedef enum logic [3:0] {
        PH_LEAD   = 4'd0,
        PH_SIGNED = 4'd1,
        PH_ZERO   = 4'd2,
        PH_DIGITS = 4'd3,
        PH_REST   = 4'd4,
        PH_DATA   = 4'd5,
        PH_SKIP1  = 4'd6,
        PH_SKIP2  = 4'd7,
        PH_HALT   = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        ACT_BYTE    = 2'd0,
        ACT_CLOSE   = 2'd1,
        ACT_RESTART = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_MALFORMED = 2'd0,
        ERR_OVER      = 2'd1,
        ERR_TRUNCATED = 2'd2
    } err_t;

    typedef struct packed {
        phase_t                phase;
        logic [SIZE_BITS-1:0]  size_value;
        logic                  saw_digit;
        logic                  sign_negative;
        logic                  pending_cr;
        logic [TOTAL_BITS-1:0] total_out;
        logic [TOTAL_BITS-1:0] left_in_chunk;
    } state_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] result_kind;
        logic [7:0] out_byte;
        logic [1:0] error_code;
    } result_t;

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c inside {[8'h61:8'h66]}) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c inside {[8'h41:8'h46]}) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    // Shift in one hex digit; once the value would pass the cap it sticks at the cap.
    function automatic state_t take_digit(state_t s, logic [3:0] d);
        state_t r;
        r = s;
        r.saw_digit = 1'b1;
        if (s.size_value[SIZE_BITS-1:COUNT_BITS-4] != '0) begin
            r.size_value = {1'b1, {COUNT_BITS{1'b0}}};
        end else begin
            r.size_value = {s.size_value[COUNT_BITS-4:0], d};
        end
        return r;
    endfunction

    function automatic state_t line_char(state_t s, logic [7:0] c);
        state_t     r;
        logic [4:0] hd;
        logic       as_signed;
        r         = s;
        hd        = hex_digit(c);
        as_signed = 1'b0;
        case (s.phase)
            PH_LEAD:
            begin
                if (c inside {8'h20, [8'h09:8'h0D]}) begin
                    r = s;
                end else if (c == CHAR_PLUS) begin
                    r.phase = PH_SIGNED;
                end else if (c == CHAR_MINUS) begin
                    r.sign_negative = 1'b1;
                    r.phase         = PH_SIGNED;
                end else begin
                    as_signed = 1'b1;
                end
            end
            PH_SIGNED:
            begin
                as_signed = 1'b1;
            end
            PH_ZERO:
            begin
                if (c == CHAR_X_LO || c == CHAR_X_UP) begin
                    r.phase = PH_DIGITS;
                end else if (hd[4]) begin
                    r       = take_digit(s, hd[3:0]);
                    r.phase = PH_DIGITS;
                end else begin
                    r.phase = PH_REST;
                end
            end
            PH_DIGITS:
            begin
                if (hd[4]) begin
                    r = take_digit(s, hd[3:0]);
                end else begin
                    r.phase = PH_REST;
                end
            end
            default:
            begin
                r = s;
            end
        endcase
        if (as_signed) begin
            if (c == CHAR_ZERO) begin
                r       = take_digit(s, 4'd0);
                r.phase = PH_ZERO;
            end else if (hd[4]) begin
                r       = take_digit(s, hd[3:0]);
                r.phase = PH_DIGITS;
            end else begin
                r.phase = PH_REST;
            end
        end
        return r;
    endfunction

endpackage

### src/hcbd_step.sv
`timescale 1ns / 1ps

// Next decoder state and optional result for one input beat.
module hcbd_step (
    input  hcbd_pkg::state_t               cur,
    input  logic [1:0]                     action,
    input  logic [7:0]                     data_byte,
    input  logic [hcbd_pkg::TOTAL_BITS-1:0] max_body_bytes,
    output hcbd_pkg::state_t               nxt,
    output hcbd_pkg::result_t              res
);

    hcbd_pkg::state_t                    cleared;
    hcbd_pkg::state_t                    after_cr;
    logic [hcbd_pkg::SUM_BITS-1:0]       sum;
    logic                                sz_zero;
    logic                                sz_sat;
    logic [hcbd_pkg::TOTAL_BITS-1:0]     left_dec;

    always_comb
    begin
        cleared               = cur;
        cleared.size_value    = '0;
        cleared.saw_digit     = 1'b0;
        cleared.sign_negative = 1'b0;
        cleared.pending_cr    = 1'b0;
    end

    assign sum = hcbd_pkg::SUM_BITS'(cur.total_out)
               + hcbd_pkg::SUM_BITS'(cur.size_value[hcbd_pkg::COUNT_BITS-1:0]);
    assign sz_zero  = (cur.size_value == '0);
    assign sz_sat   = cur.size_value[hcbd_pkg::COUNT_BITS];
    assign left_dec = (cur.left_in_chunk != '0)
                    ? cur.left_in_chunk - hcbd_pkg::TOTAL_BITS'(1)
                    : cur.left_in_chunk;

    always_comb
    begin
        nxt                = cur;
        res.valid          = 1'b0;
        res.result_kind    = hcbd_pkg::KIND_DATA;
        res.out_byte       = 8'd0;
        res.error_code     = hcbd_pkg::ERR_MALFORMED;
        after_cr           = cur;
        after_cr.pending_cr = 1'b0;

        case (action)
            hcbd_pkg::ACT_RESTART:
            begin
                nxt               = cleared;
                nxt.phase         = hcbd_pkg::PH_LEAD;
                nxt.total_out     = '0;
                nxt.left_in_chunk = '0;
            end
            hcbd_pkg::ACT_CLOSE:
            begin
                if (cur.phase != hcbd_pkg::PH_HALT) begin
                    nxt.phase      = hcbd_pkg::PH_HALT;
                    res.valid      = 1'b1;
                    res.result_kind = hcbd_pkg::KIND_ERROR;
                    res.error_code = hcbd_pkg::ERR_TRUNCATED;
                end
            end
            hcbd_pkg::ACT_BYTE:
            begin
                case (cur.phase)
                    hcbd_pkg::PH_HALT:
                    begin
                        nxt = cur;
                    end
                    hcbd_pkg::PH_DATA:
                    begin
                        nxt.left_in_chunk = left_dec;
                        if (left_dec == '0) begin
                            nxt.phase = hcbd_pkg::PH_SKIP1;
                        end
                        res.valid    = 1'b1;
                        res.out_byte = data_byte;
                    end
                    hcbd_pkg::PH_SKIP1:
                    begin
                        nxt.phase = hcbd_pkg::PH_SKIP2;
                    end
                    hcbd_pkg::PH_SKIP2:
                    begin
                        nxt       = cleared;
                        nxt.phase = hcbd_pkg::PH_LEAD;
                    end
                    default:
                    begin
                        if (cur.pending_cr && data_byte == hcbd_pkg::CHAR_LF) begin
                            // End of the size line.
                            nxt       = cleared;
                            nxt.phase = hcbd_pkg::PH_HALT;
                            res.valid = 1'b1;
                            res.result_kind = hcbd_pkg::KIND_ERROR;
                            if (!cur.saw_digit) begin
                                res.error_code = hcbd_pkg::ERR_MALFORMED;
                            end else if (cur.sign_negative && !sz_zero) begin
                                res.error_code = hcbd_pkg::ERR_OVER;
                            end else if (sz_zero) begin
                                res.result_kind = hcbd_pkg::KIND_DONE;
                            end else if (sz_sat ||
                                         sum > hcbd_pkg::SUM_BITS'(max_body_bytes)) begin
                                res.error_code = hcbd_pkg::ERR_OVER;
                            end else begin
                                res.valid         = 1'b0;
                                nxt.phase         = hcbd_pkg::PH_DATA;
                                nxt.total_out     = hcbd_pkg::TOTAL_BITS'(sum);
                                nxt.left_in_chunk = hcbd_pkg::TOTAL_BITS'(
                                    cur.size_value[hcbd_pkg::COUNT_BITS-1:0]);
                            end
                        end else begin
                            // A CR not followed by LF is an ordinary line character.
                            if (cur.pending_cr) begin
                                after_cr = hcbd_pkg::line_char(after_cr, hcbd_pkg::CHAR_CR);
                            end
                            if (data_byte == hcbd_pkg::CHAR_CR) begin
                                nxt            = after_cr;
                                nxt.pending_cr = 1'b1;
                            end else if (data_byte == hcbd_pkg::CHAR_SEMI) begin
                                // Extensions from ';' on never add digits.
                                nxt = hcbd_pkg::line_char(after_cr, data_byte);
                            end else begin
                                nxt = hcbd_pkg::line_char(after_cr, data_byte);
                            end
                        end
                    end
                endcase
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

### src/http_chunked_body_decoder.sv
`timescale 1ns / 1ps

// Chunked body decoder: accepts one beat (body byte, close or restart) per clock and
// gives at most one result beat for it, passing first through the input register and
// then the result register. Sustained rate is one beat per cycle; it falls only while
// the result register is stalled. The slowest path is the size-line end, where the
// running total plus the chunk size is added and compared against max_body_bytes in
// one 33-bit add and compare.
`include "http_chunked_body_decoder_defines.svh"

module http_chunked_body_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  result_kind,
    output logic [7:0]  out_byte,
    output logic [1:0]  error_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    logic                                s1_valid_reg;
    logic [1:0]                          s1_action_reg;
    logic [7:0]                          s1_byte_reg;
    logic                                s1_advance;
    hcbd_pkg::state_t                    state_reg;
    hcbd_pkg::state_t                    state_next;
    hcbd_pkg::result_t                   res_next;
    logic [hcbd_pkg::TOTAL_BITS-1:0]     max_body_reg;
    logic                                out_valid_reg;
    logic [1:0]                          kind_reg;
    logic [7:0]                          byte_reg;
    logic [1:0]                          code_reg;

    assign cfg_ready  = 1'b1;
    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = s1_valid_reg && !s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_body_reg <= hcbd_pkg::MAX_BODY_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_body_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (!in_stall) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall) begin
            s1_action_reg <= action;
            s1_byte_reg   <= data_byte;
        end
    end

    hcbd_step u_step (
        .cur            (state_reg),
        .action         (s1_action_reg),
        .data_byte      (s1_byte_reg),
        .max_body_bytes (max_body_reg),
        .nxt            (state_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg.phase         <= hcbd_pkg::PH_LEAD;
            state_reg.size_value    <= '0;
            state_reg.saw_digit     <= 1'b0;
            state_reg.sign_negative <= 1'b0;
            state_reg.pending_cr    <= 1'b0;
            state_reg.total_out     <= '0;
            state_reg.left_in_chunk <= '0;
        end else if (s1_valid_reg && s1_advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (s1_valid_reg && s1_advance) begin
            out_valid_reg <= res_next.valid;
        end else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_advance && res_next.valid) begin
            kind_reg <= res_next.result_kind;
            byte_reg <= res_next.out_byte;
            code_reg <= res_next.error_code;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign out_byte    = byte_reg;
    assign error_code  = code_reg;

    // A held input beat must not be consumed or altered while the result side is stalled.
    `HCBD_ASSERT_NEXT(a_s1_hold, s1_valid_reg && !s1_advance,
        s1_valid_reg && $stable(s1_action_reg) && $stable(s1_byte_reg),
        "input stage lost a held beat")
    // Once halted, only a restart may change the decoder state.
    `HCBD_ASSERT_NEXT(a_halt_sticky,
        s1_valid_reg && s1_advance && state_reg.phase == hcbd_pkg::PH_HALT &&
        s1_action_reg != hcbd_pkg::ACT_RESTART,
        $stable(state_reg), "halted decoder changed state")
    // Non-error results carry a zero error code.
    `HCBD_ASSERT_IMP(a_code_zero,
        out_valid_reg && kind_reg != hcbd_pkg::KIND_ERROR,
        code_reg == hcbd_pkg::ERR_MALFORMED, "error code set on a non-error result")

endmodule

### dv/tb_http_chunked_body_decoder.sv
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;

    import hcbd_pkg::*;

    localparam logic [1:0] ACT_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         WATCHDOG_MAX  = 4000;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_Z     = 8'h7A;

    localparam logic [32:0] SIZE_CAP  = 33'h1_0000_0000;
    localparam logic [32:0] SHIFT_CAP = 33'h0_1000_0000;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        err_t       code;
    } decoded_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic [7:0]  out_byte;
    logic [1:0]  error_code;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    // Decoder state as predicted from the accepted input beats.
    phase_t      dec_phase;
    logic [32:0] size_acc;
    logic        seen_digit;
    logic        minus_seen;
    logic        cr_held;
    logic [31:0] body_total;
    logic [31:0] chunk_left;
    logic [31:0] body_limit;

    decoded_t    expected_q[$];

    bit          idle_on = 1'b1;
    bit          cut_armed = 1'b0;
    int unsigned sent_items = 0;
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned n_data = 0;
    int unsigned n_done = 0;
    int unsigned n_malformed = 0;
    int unsigned n_over = 0;
    int unsigned n_truncated = 0;
    int unsigned limit_settings = 0;

    http_chunked_body_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .data_byte   (data_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .out_byte    (out_byte),
        .error_code  (error_code),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic int hex_value(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CH_NINE)
        begin
            return int'(c - CHAR_ZERO);
        end
        if (c >= CH_A_LO && c <= CH_F_LO)
        begin
            return int'(c - CH_A_LO) + 10;
        end
        if (c >= CH_A_UP && c <= CH_F_UP)
        begin
            return int'(c - CH_A_UP) + 10;
        end
        return -1;
    endfunction

    task automatic clear_size_line();
        size_acc   = '0;
        seen_digit = 1'b0;
        minus_seen = 1'b0;
        cr_held    = 1'b0;
    endtask

    task automatic restart_body();
        dec_phase  = PH_LEAD;
        clear_size_line();
        body_total = '0;
        chunk_left = '0;
    endtask

    // The size sticks at the cap once another digit would carry past it.
    task automatic push_digit(input int d);
        seen_digit = 1'b1;
        if (size_acc >= SHIFT_CAP)
        begin
            size_acc = SIZE_CAP;
        end
        else
        begin
            size_acc = (size_acc << 4) | 33'(d);
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        int d;
        bit numeric;
        d       = hex_value(c);
        numeric = 1'b0;
        case (dec_phase)
            PH_LEAD:
            begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CHAR_CR))
                begin
                    numeric = 1'b0;
                end
                else if (c == CHAR_PLUS)
                begin
                    dec_phase = PH_SIGNED;
                end
                else if (c == CHAR_MINUS)
                begin
                    minus_seen = 1'b1;
                    dec_phase  = PH_SIGNED;
                end
                else
                begin
                    numeric = 1'b1;
                end
            end
            PH_SIGNED:
            begin
                numeric = 1'b1;
            end
            PH_ZERO:
            begin
                if (c == CHAR_X_LO || c == CHAR_X_UP)
                begin
                    dec_phase = PH_DIGITS;
                end
                else if (d >= 0)
                begin
                    push_digit(d);
                    dec_phase = PH_DIGITS;
                end
                else
                begin
                    dec_phase = PH_REST;
                end
            end
            PH_DIGITS:
            begin
                if (d >= 0)
                begin
                    push_digit(d);
                end
                else
                begin
                    dec_phase = PH_REST;
                end
            end
            default:
            begin
                numeric = 1'b0;
            end
        endcase
        if (numeric)
        begin
            if (c == CHAR_ZERO)
            begin
                push_digit(0);
                dec_phase = PH_ZERO;
            end
            else if (d >= 0)
            begin
                push_digit(d);
                dec_phase = PH_DIGITS;
            end
            else
            begin
                dec_phase = PH_REST;
            end
        end
    endtask

    task automatic close_line(output bit got, output decoded_t r);
        logic [32:0] sz;
        logic        neg;
        logic        any;
        sz  = size_acc;
        neg = minus_seen;
        any = seen_digit;
        clear_size_line();
        got    = 1'b1;
        r.kind = KIND_ERROR;
        r.data = 8'h00;
        r.code = ERR_MALFORMED;
        dec_phase = PH_HALT;
        if (!any)
        begin
            r.code = ERR_MALFORMED;
        end
        else if (neg && sz != '0)
        begin
            r.code = ERR_OVER;
        end
        else if (sz == '0)
        begin
            r.kind = KIND_DONE;
        end
        else if (sz[32] || (34'(body_total) + 34'(sz)) > 34'(body_limit))
        begin
            r.code = ERR_OVER;
        end
        else
        begin
            got        = 1'b0;
            body_total = body_total + sz[31:0];
            chunk_left = sz[31:0];
            dec_phase  = PH_DATA;
        end
    endtask

    task automatic decode_beat(input logic [1:0] act, input logic [7:0] c);
        decoded_t r;
        bit       got;
        bit       line_end;
        r.kind   = KIND_DATA;
        r.data   = 8'h00;
        r.code   = ERR_MALFORMED;
        got      = 1'b0;
        line_end = 1'b0;
        if (act == ACT_RESTART)
        begin
            restart_body();
        end
        else if (act != ACT_UNUSED && dec_phase != PH_HALT)
        begin
            if (act == ACT_CLOSE)
            begin
                dec_phase = PH_HALT;
                got       = 1'b1;
                r.kind    = KIND_ERROR;
                r.code    = ERR_TRUNCATED;
            end
            else
            begin
                case (dec_phase)
                    PH_DATA:
                    begin
                        if (chunk_left != '0)
                        begin
                            chunk_left--;
                        end
                        if (chunk_left == '0)
                        begin
                            dec_phase = PH_SKIP1;
                        end
                        got    = 1'b1;
                        r.data = c;
                    end
                    PH_SKIP1:
                    begin
                        dec_phase = PH_SKIP2;
                    end
                    PH_SKIP2:
                    begin
                        dec_phase = PH_LEAD;
                        clear_size_line();
                    end
                    default:
                    begin
                        // A held CR ends the line only when LF follows it.
                        if (cr_held)
                        begin
                            cr_held = 1'b0;
                            if (c == CHAR_LF)
                            begin
                                line_end = 1'b1;
                                close_line(got, r);
                            end
                            else
                            begin
                                scan_char(CHAR_CR);
                            end
                        end
                        if (!line_end)
                        begin
                            if (c == CHAR_CR)
                            begin
                                cr_held = 1'b1;
                            end
                            else
                            begin
                                scan_char(c);
                            end
                        end
                    end
                endcase
            end
        end
        if (got)
        begin
            expected_q.insert(expected_q.size(), r);
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic send_beat(input logic [1:0] act, input logic [7:0] c);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        data_byte <= c;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sent_items++;
        decode_beat(act, c);
    endtask

    task automatic send_line(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(ACT_BYTE, s[i]);
        end
        send_beat(ACT_BYTE, CHAR_CR);
        send_beat(ACT_BYTE, CHAR_LF);
    endtask

    // Body byte that may be preceded by a close (truncation) or an unused action.
    task automatic put_byte(input logic [7:0] c);
        if (cut_armed && $urandom_range(0, 19) == 0)
        begin
            cut_armed = 1'b0;
            send_beat(ACT_CLOSE, 8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 63) == 0)
        begin
            send_beat(ACT_UNUSED, 8'($urandom_range(0, 255)));
        end
        send_beat(ACT_BYTE, c);
    endtask

    task automatic write_limit(input logic [31:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid  <= 1'b0;
        body_limit = v;
        limit_settings++;
    endtask

    // Hold the sender until every expected result is out and the pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Random body generation
    // ------------------------------------------------------------------

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10)
        begin
            return CHAR_ZERO + 8'(nib);
        end
        return ($urandom_range(0, 1) ? CH_A_LO : CH_A_UP) + 8'(nib) - 8'd10;
    endfunction

    task automatic put_hex(input logic [63:0] v);
        int msd;
        msd = 0;
        for (int i = 0; i < 16; i++)
        begin
            if (v[i*4 +: 4] != 4'h0)
            begin
                msd = i;
            end
        end
        if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 2)) put_byte(CHAR_ZERO);
        end
        for (int i = msd; i >= 0; i--)
        begin
            put_byte(hex_char(v[i*4 +: 4]));
        end
    endtask

    task automatic put_size_line(input logic [63:0] v, input bit neg);
        logic [7:0] ws [5];
        ws = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CHAR_CR};
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 2)) put_byte(ws[$urandom_range(0, 4)]);
        end
        if (neg)
        begin
            put_byte(CHAR_MINUS);
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            put_byte(CHAR_PLUS);
        end
        if ($urandom_range(0, 6) == 0)
        begin
            put_byte(CHAR_ZERO);
            put_byte($urandom_range(0, 1) ? CHAR_X_LO : CHAR_X_UP);
        end
        put_hex(v);
        if ($urandom_range(0, 9) == 0)
        begin
            // A CR that is not followed by LF just ends the number.
            put_byte(CHAR_CR);
            put_byte(CH_Z);
        end
        if ($urandom_range(0, 6) == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                put_byte(CH_SPACE);
            end
            put_byte(CHAR_SEMI);
            repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(32, 126)));
        end
        put_byte(CHAR_CR);
        put_byte(CHAR_LF);
    endtask

    task automatic put_garbage_line();
        logic [7:0] c;
        repeat ($urandom_range(1, 4))
        begin
            c = 8'($urandom_range(0, 255));
            if (hex_value(c) >= 0)
            begin
                c = CH_Z;
            end
            put_byte(c);
        end
        put_byte(CHAR_CR);
        put_byte(CHAR_LF);
    endtask

    function automatic logic [63:0] pick_chunk_size();
        logic [63:0] room;
        int          r;
        room = 64'(body_limit) - 64'(body_total);
        r    = $urandom_range(0, 99);
        if (r < 70)
        begin
            return 64'($urandom_range(1, 6));
        end
        if (r < 76)
        begin
            return 64'($urandom_range(16, 40));
        end
        if (r < 81)
        begin
            return 64'h0;
        end
        if (r < 87 && body_limit >= body_total && room >= 1 && room <= 16)
        begin
            return room;
        end
        if (r < 93)
        begin
            return room + 64'd1;
        end
        return {28'h0, 4'($urandom_range(1, 15)), 32'($urandom)};
    endfunction

    task automatic random_body();
        logic [63:0] sz;
        int          chunks;
        cut_armed = ($urandom_range(0, 15) == 0);
        chunks    = $urandom_range(0, 4);
        for (int k = 0; k < chunks; k++)
        begin
            sz = pick_chunk_size();
            if ($urandom_range(0, 19) == 0)
            begin
                put_garbage_line();
            end
            else
            begin
                put_size_line(sz, $urandom_range(0, 29) == 0);
            end
            if (sz <= 64'd64)
            begin
                repeat (int'(sz)) put_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) != 0)
                begin
                    put_byte(CHAR_CR);
                    put_byte(CHAR_LF);
                end
                else
                begin
                    put_byte(8'($urandom_range(0, 255)));
                    put_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        put_size_line(64'h0, $urandom_range(0, 19) == 0);
        // Beats after the end of a body must be ignored.
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
            send_beat(ACT_CLOSE, 8'($urandom_range(0, 255)));
        end
        cut_armed = 1'b0;
        send_beat(ACT_RESTART, 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_halt_and_unused();
        send_beat(ACT_CLOSE, 8'h00);
        send_beat(ACT_BYTE, 8'hFF);
        send_beat(ACT_UNUSED, 8'hA5);
        send_beat(ACT_RESTART, 8'h5A);
    endtask

    task automatic test_size_prefixes();
        send_line("-0");
        send_beat(ACT_RESTART, 8'h00);
        send_beat(ACT_BYTE, CHAR_CR);
        send_line("0x");
        send_beat(ACT_RESTART, 8'h00);
    endtask

    task automatic test_size_line_errors();
        send_line("-1");
        send_beat(ACT_RESTART, 8'h00);
        send_line("");
        send_beat(ACT_RESTART, 8'h00);
    endtask

    task automatic test_close_in_chunk();
        send_line("1");
        send_beat(ACT_BYTE, 8'h00);
        send_beat(ACT_CLOSE, 8'hFF);
        send_beat(ACT_RESTART, 8'h00);
    endtask

    task automatic test_random_bodies(input int unsigned n);
        int unsigned goal;
        goal = sent_items + n;
        while (sent_items < goal)
        begin
            random_body();
        end
    endtask

    task automatic test_limit_zero();
        settle();
        write_limit(32'h0000_0000);
        send_line("1");
        send_beat(ACT_RESTART, 8'h00);
        send_line("0");
        send_beat(ACT_RESTART, 8'h00);
        test_random_bodies(200);
    endtask

    task automatic test_limit_max();
        settle();
        write_limit(32'hFFFF_FFFF);
        send_line("100000000");
        send_beat(ACT_RESTART, 8'h00);
        test_random_bodies(350);
    endtask

    task automatic test_limit_tight();
        settle();
        write_limit(32'd24);
        test_random_bodies(300);
    endtask

    task automatic test_limit_random();
        settle();
        write_limit(32'($urandom_range(40, 200)));
        test_random_bodies(200);
    endtask

    task automatic test_steady_stream();
        settle();
        idle_on = 1'b0;
        write_limit(MAX_BODY_RESET);
        test_random_bodies(200);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic log_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk)
    begin
        decoded_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                log_failure($sformatf("unexpected result beat kind %0d byte %02h code %0d",
                                      result_kind, out_byte, error_code));
            end
            else
            begin
                want = expected_q.pop_front();
                if (result_kind !== want.kind || out_byte !== want.data
                    || error_code !== want.code)
                begin
                    log_failure($sformatf(
                        "kind exp %0d got %0d, byte exp %02h got %02h, code exp %0d got %0d",
                        want.kind, result_kind, want.data, out_byte, want.code, error_code));
                end
                else if (want.kind == KIND_DATA)
                begin
                    n_data++;
                end
                else if (want.kind == KIND_DONE)
                begin
                    n_done++;
                end
                else if (want.code == ERR_MALFORMED)
                begin
                    n_malformed++;
                end
                else if (want.code == ERR_OVER)
                begin
                    n_over++;
                end
                else
                begin
                    n_truncated++;
                end
            end
        end
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 11) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Ends the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_MAX)
        begin
            $display("Watchdog expired with %0d results outstanding.", expected_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        action    <= ACT_BYTE;
        data_byte <= 8'h00;
        cfg_valid <= 1'b0;
        cfg_data  <= 32'h0;
        body_limit = MAX_BODY_RESET;
        restart_body();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_halt_and_unused();
        test_size_prefixes();
        test_size_line_errors();
        test_close_in_chunk();
        test_random_bodies(400);
        test_limit_zero();
        test_limit_max();
        test_limit_tight();
        test_limit_random();
        test_steady_stream();
        settle();

        if (expected_q.size() != 0)
        begin
            log_failure($sformatf("%0d expected results never arrived", expected_q.size()));
        end
        $display("Checked %0d payload bytes, %0d completed bodies and %0d errors",
                 n_data, n_done, n_malformed + n_over + n_truncated);
        $display("(malformed %0d, over limit %0d, truncated %0d) over %0d limit settings.",
                 n_malformed, n_over, n_truncated, limit_settings);
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("%0d failures in total.", fail_count);
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+src
src/hcbd_pkg.sv
src/hcbd_step.sv
src/http_chunked_body_decoder.sv
dv/tb_http_chunked_body_decoder.sv
